// ===== rtl/core/gsmj_pkg.sv =====
// ----------------------------------------------------------------------------
// gsmj_pkg: shared types and constants for the Gaussian sum model
// Payload structs, function codes, divider request and the 2^f table.
// ----------------------------------------------------------------------------
package gsmj_pkg;

  localparam int MAX_TERMS      = 8;
  localparam int TIDX_W         = $clog2(MAX_TERMS);
  localparam int TCNT_W         = $clog2(MAX_TERMS + 1);
  localparam int SUM_W          = 31 + $clog2(MAX_TERMS + 1);

  localparam int EXP_TABLE_BITS = 10;
  localparam int EXP_LOW_W      = 16 - EXP_TABLE_BITS;
  localparam int EXP_TAB_N      = (1 << EXP_TABLE_BITS) + 1;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [31:0] LOG2E_Q16 = 32'd94548;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 31;
  localparam int DIV_REM_W = DIV_DEN_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_EVAL = 2'd1;
  localparam logic [1:0] FUNC_JAC  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         term_index;
    logic signed [31:0] log_amplitude;
    logic signed [31:0] center;
    logic [30:0]        width;
    logic signed [31:0] wavelength;
    logic signed [31:0] scale;
  } gsmj_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] deriv_center;
    logic signed [31:0] deriv_width;
    logic [3:0]         result_term;
    logic               last;
  } gsmj_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } gsmj_div_req_t;

  typedef logic [31:0] exp_tab_t [EXP_TAB_N];

  function automatic logic [31:0] exp2_entry(input int unsigned i);
    logic [63:0] u;
    logic [63:0] tm;
    logic [63:0] s;
    u  = (64'(i) * LN2_Q30) >> EXP_TABLE_BITS;
    tm = 64'd1 << 30;
    s  = tm;
    tm = ((tm * u) >> 30) / 1;  s = s + tm;
    tm = ((tm * u) >> 30) / 2;  s = s + tm;
    tm = ((tm * u) >> 30) / 3;  s = s + tm;
    tm = ((tm * u) >> 30) / 4;  s = s + tm;
    tm = ((tm * u) >> 30) / 5;  s = s + tm;
    tm = ((tm * u) >> 30) / 6;  s = s + tm;
    tm = ((tm * u) >> 30) / 7;  s = s + tm;
    tm = ((tm * u) >> 30) / 8;  s = s + tm;
    tm = ((tm * u) >> 30) / 9;  s = s + tm;
    tm = ((tm * u) >> 30) / 10; s = s + tm;
    tm = ((tm * u) >> 30) / 11; s = s + tm;
    tm = ((tm * u) >> 30) / 12; s = s + tm;
    return s[31:0];
  endfunction

  function automatic exp_tab_t exp_tab_init();
    exp_tab_t tab;
    for (int i = 0; i < EXP_TAB_N; i++) begin
      tab[i] = exp2_entry(i);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP2_TAB = exp_tab_init();

endpackage

// ===== rtl/core/gsmj_div.sv =====
// ----------------------------------------------------------------------------
// gsmj_div: iterative unsigned divider
// Restoring shift-subtract, one quotient bit per cycle, done pulses at end.
// ----------------------------------------------------------------------------
module gsmj_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gsmj_pkg::gsmj_div_req_t          req,
  output logic                             done,
  output logic [gsmj_pkg::DIV_NUM_W-1:0]   quo
);
  import gsmj_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_REM_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_REM_W-1:0] rem_sh;
  logic [DIV_REM_W-1:0] rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_r[DIV_REM_W-2:0], quo_r[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r <= '0;
        quo_r <= req.num;
        den_r <= req.den;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? rem_sub : rem_sh;
        quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/gaussian_sum_model_jacobian.sv =====
// ----------------------------------------------------------------------------
// gaussian_sum_model_jacobian: sum of Gaussians model with Jacobian rows
// Terms are loaded one per item; evaluate and jacobian items walk the terms
// with one 64-step divider and one 32x32 multiplier, all values Q16.16.
//
// Input channel in_valid/in_ready/in_data: one item per transfer. A load gives
// no result. Evaluate gives one result, jacobian gives min(term_count,8)+1
// results, the last one flagged.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes term_count;
// cfg_ready is always high.
// Each term takes three passes of the shared divider plus the exp steps;
// each output product is formed on the multiplier, three per jacobian row.
// in_ready is high only in idle; one item is worked at a time.
// Results sit in an output register; a stalled receiver holds the
// sequencer until out_ready. Reset returns to idle, drops any pending
// result and sets term_count to 1; term tables keep no reset value.
// ----------------------------------------------------------------------------
module gaussian_sum_model_jacobian (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gsmj_pkg::gsmj_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gsmj_pkg::gsmj_out_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);
  import gsmj_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DST  = 4'd1;
  localparam logic [3:0] S_DWT  = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_E1   = 4'd4;
  localparam logic [3:0] S_E2   = 4'd5;
  localparam logic [3:0] S_E3   = 4'd6;
  localparam logic [3:0] S_E4   = 4'd7;
  localparam logic [3:0] S_OST  = 4'd8;
  localparam logic [3:0] S_MQ   = 4'd9;
  localparam logic [3:0] S_MQF  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [1:0] DSEL_Z  = 2'd0;
  localparam logic [1:0] DSEL_GC = 2'd1;
  localparam logic [1:0] DSEL_GW = 2'd2;

  localparam logic [1:0] OS_EVAL = 2'd0;
  localparam logic [1:0] OS_ROWP = 2'd1;
  localparam logic [1:0] OS_ROWC = 2'd2;
  localparam logic [1:0] OS_ROWW = 2'd3;

  localparam logic [63:0]        Z_CAP     = 64'h0000_0000_8000_0000;
  localparam logic signed [48:0] ARG_LIM   = 49'sd2097152;
  localparam logic [22:0]        ARG_OFF   = 23'd2097152;
  localparam logic [63:0]        EXP_ADJ   = (64'd64 << 32) - (64'(LOG2E_Q16) << 21);
  localparam logic [6:0]         N_SAT     = 7'd80;
  localparam logic [6:0]         N_SHL     = 7'd78;
  localparam logic [95:0]        MAG_LIMIT = 96'd1 << 46;

  function automatic logic [46:0] mag47(input logic signed [47:0] a);
    logic signed [47:0] n;
    n = -a;
    mag47 = a[47] ? n[46:0] : a[46:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < -48'sh0000_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  logic [3:0]              state_r;
  logic [31:0]             amp_mem [MAX_TERMS];
  logic [31:0]             ctr_mem [MAX_TERMS];
  logic [30:0]             wid_mem [MAX_TERMS];
  logic [30:0]             t_mem   [MAX_TERMS];
  logic [47:0]             gc_mem  [MAX_TERMS];
  logic [62:0]             gw_mem  [MAX_TERMS];
  logic [MAX_TERMS-1:0]    gneg_r;
  logic [3:0]              term_count_r;
  logic [TCNT_W-1:0]       nterms_r;
  logic [TCNT_W-1:0]       k_r;
  logic [TCNT_W-1:0]       k_inc;
  logic [TIDX_W-1:0]       kidx;
  logic [1:0]              func_r;
  logic signed [31:0]      lam_r;
  logic signed [31:0]      scale_r;
  logic [SUM_W-1:0]        sum_r;
  logic [1:0]              dsel_r;
  logic [31:0]             z_r;
  logic [63:0]             zz_r;
  logic [47:0]             gc_r;
  logic [62:0]             gw_r;
  logic                    dneg_r;
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             mul_r;
  logic [6:0]              n_r;
  logic [EXP_LOW_W-1:0]    frem_r;
  logic [31:0]             t0_r;
  logic [31:0]             t1_r;
  logic [46:0]             mq_ma_r;
  logic [62:0]             mq_mb_r;
  logic                    mq_neg_r;
  logic [2:0]              mq_cnt_r;
  logic [111:0]            acc_r;
  logic signed [47:0]      p_r;
  logic signed [31:0]      dc_r;
  logic [1:0]              ostep_r;
  logic                    out_valid_r;
  gsmj_out_t               out_data_r;

  gsmj_div_req_t           div_req;
  logic                    div_done;
  logic [DIV_NUM_W-1:0]    div_quo;

  logic signed [32:0]      d33;
  logic [32:0]             md;
  logic [30:0]             w_eff;
  logic signed [48:0]      arg;
  logic signed [48:0]      arg_c;
  logic [22:0]             ua;
  logic [63:0]             yb;
  logic [EXP_TABLE_BITS:0] tidx0;
  logic [EXP_TABLE_BITS:0] tidx1;
  logic [32:0]             m33;
  logic [32:0]             m_shl;
  logic [30:0]             t_val;
  logic [1:0]              pair;
  logic [1:0]              prev;
  logic [6:0]              acc_sh;
  logic                    mq_big;
  logic [46:0]             mq_mag;
  logic signed [47:0]      mq_res;
  logic signed [47:0]      ln_a;
  logic [62:0]             ln_b;
  logic                    ln_bneg;

  assign kidx  = k_r[TIDX_W-1:0];
  assign k_inc = k_r + TCNT_W'(1);

  // term geometry
  always_comb begin
    d33   = {lam_r[31], lam_r} - {ctr_mem[kidx][31], ctr_mem[kidx]};
    md    = d33[32] ? 33'(-d33) : 33'(d33);
    w_eff = (wid_mem[kidx] == '0) ? 31'd1 : wid_mem[kidx];
  end

  always_comb begin
    div_req.start = (state_r == S_DST);
    div_req.den   = w_eff;
    case (dsel_r)
      DSEL_Z:  div_req.num = {15'b0, md, 16'b0};
      DSEL_GC: div_req.num = {16'b0, z_r, 16'b0};
      DSEL_GW: div_req.num = zz_r;
      default: div_req.num = '0;
    endcase
  end

  gsmj_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // exp argument and table index
  always_comb begin
    arg = $signed({{17{amp_mem[kidx][31]}}, amp_mem[kidx]}) - $signed({2'b0, zz_r[63:17]});
    if (arg > ARG_LIM) begin
      arg_c = ARG_LIM;
    end else if (arg < -ARG_LIM) begin
      arg_c = -ARG_LIM;
    end else begin
      arg_c = arg;
    end
    ua    = arg_c[22:0] + ARG_OFF;
    yb    = mul_r + EXP_ADJ;
    tidx0 = {1'b0, yb[31:32-EXP_TABLE_BITS]};
    tidx1 = tidx0 + (EXP_TABLE_BITS+1)'(1);
  end

  always_comb begin
    m33   = {1'b0, t0_r} + 33'(mul_r >> EXP_LOW_W);
    m_shl = {1'b0, m33[31:0]} << (n_r - N_SHL);
    if (n_r >= N_SAT) begin
      t_val = 31'h7FFF_FFFF;
    end else if (n_r >= N_SHL) begin
      t_val = (m_shl > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : m_shl[30:0];
    end else begin
      t_val = 31'(m33[31:0] >> (N_SHL - n_r));
    end
  end

  // signed product partial sums
  always_comb begin
    pair   = mq_cnt_r[1:0];
    prev   = mq_cnt_r[1:0] - 2'd1;
    case (prev)
      2'd0:    acc_sh = 7'd0;
      2'd3:    acc_sh = 7'd64;
      default: acc_sh = 7'd32;
    endcase
    mq_big = acc_r[111:16] > MAG_LIMIT;
    mq_mag = mq_big ? MAG_LIMIT[46:0] : acc_r[62:16];
    mq_res = mq_neg_r ? -$signed({1'b0, mq_mag}) : $signed({1'b0, mq_mag});
  end

  // shared multiplier operands
  always_comb begin
    case (state_r)
      S_SQ: begin
        mul_a = z_r;
        mul_b = z_r;
      end
      S_E1: begin
        mul_a = 32'(ua);
        mul_b = LOG2E_Q16;
      end
      S_E3: begin
        mul_a = t1_r - t0_r;
        mul_b = 32'(frem_r);
      end
      S_MQ: begin
        mul_a = pair[1] ? {17'b0, mq_ma_r[46:32]} : mq_ma_r[31:0];
        mul_b = pair[0] ? {1'b0, mq_mb_r[62:32]} : mq_mb_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= 64'(mul_a) * 64'(mul_b);
  end

  // operands of the next product
  always_comb begin
    ln_a    = 48'(scale_r);
    ln_b    = 63'(t_mem[kidx]);
    ln_bneg = 1'b0;
    case (state_r)
      S_OST: ln_b = 63'(sum_r);
      S_MQF: begin
        if (ostep_r == OS_ROWP) begin
          ln_a    = mq_res;
          ln_b    = 63'(gc_mem[kidx]);
          ln_bneg = gneg_r[kidx];
        end else begin
          ln_a = p_r;
          ln_b = gw_mem[kidx];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      term_count_r <= 4'd1;
      k_r          <= '0;
      nterms_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        term_count_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_data.func)
              FUNC_LOAD: begin
                if (int'(in_data.term_index) < MAX_TERMS) begin
                  amp_mem[TIDX_W'(in_data.term_index)] <= in_data.log_amplitude;
                  ctr_mem[TIDX_W'(in_data.term_index)] <= in_data.center;
                  wid_mem[TIDX_W'(in_data.term_index)] <= in_data.width;
                end
              end
              FUNC_EVAL, FUNC_JAC: begin
                func_r  <= in_data.func;
                lam_r   <= in_data.wavelength;
                scale_r <= in_data.scale;
                sum_r   <= '0;
                k_r     <= '0;
                dsel_r  <= DSEL_Z;
                nterms_r <= (int'(term_count_r) > MAX_TERMS) ? TCNT_W'(MAX_TERMS)
                                                             : TCNT_W'(term_count_r);
                state_r <= (term_count_r == 4'd0) ? S_OST : S_DST;
              end
              default: ;
            endcase
          end
        end
        S_DST: begin
          if (dsel_r == DSEL_GC) begin
            zz_r <= mul_r;
          end
          if (dsel_r == DSEL_Z) begin
            dneg_r <= d33[32];
          end
          state_r <= S_DWT;
        end
        S_DWT: begin
          if (div_done) begin
            case (dsel_r)
              DSEL_Z: begin
                z_r     <= (div_quo > Z_CAP) ? 32'h8000_0000 : div_quo[31:0];
                state_r <= S_SQ;
              end
              DSEL_GC: begin
                gc_r    <= div_quo[47:0];
                dsel_r  <= DSEL_GW;
                state_r <= S_DST;
              end
              DSEL_GW: begin
                gw_r    <= div_quo[62:0];
                state_r <= S_E1;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SQ: begin
          dsel_r  <= DSEL_GC;
          state_r <= S_DST;
        end
        S_E1: state_r <= S_E2;
        S_E2: begin
          n_r     <= yb[38:32];
          frem_r  <= yb[31-EXP_TABLE_BITS:16];
          t0_r    <= EXP2_TAB[tidx0];
          t1_r    <= EXP2_TAB[tidx1];
          state_r <= S_E3;
        end
        S_E3: state_r <= S_E4;
        S_E4: begin
          t_mem[kidx]  <= t_val;
          gc_mem[kidx] <= gc_r;
          gw_mem[kidx] <= gw_r;
          gneg_r[kidx] <= dneg_r;
          sum_r        <= sum_r + SUM_W'(t_val);
          if (k_inc == nterms_r) begin
            k_r     <= '0;
            state_r <= S_OST;
          end else begin
            k_r     <= k_inc;
            dsel_r  <= DSEL_Z;
            state_r <= S_DST;
          end
        end
        S_OST: begin
          if (func_r == FUNC_EVAL) begin
            mq_ma_r  <= mag47(ln_a);
            mq_mb_r  <= ln_b;
            mq_neg_r <= ln_a[47] ^ ln_bneg;
            acc_r    <= '0;
            mq_cnt_r <= '0;
            ostep_r  <= OS_EVAL;
            state_r  <= S_MQ;
          end else begin
            out_data_r.value        <= (sum_r > SUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                     : sum_r[31:0];
            out_data_r.deriv_center <= '0;
            out_data_r.deriv_width  <= '0;
            out_data_r.result_term  <= 4'd0;
            out_data_r.last         <= (nterms_r == '0);
            out_valid_r             <= 1'b1;
            state_r                 <= S_OUT;
          end
        end
        S_MQ: begin
          if (mq_cnt_r != 3'd0) begin
            acc_r <= acc_r + (112'(mul_r) << acc_sh);
          end
          mq_cnt_r <= mq_cnt_r + 3'd1;
          if (mq_cnt_r == 3'd4) begin
            state_r <= S_MQF;
          end
        end
        S_MQF: begin
          case (ostep_r)
            OS_EVAL: begin
              out_data_r.value        <= sat32(mq_res);
              out_data_r.deriv_center <= '0;
              out_data_r.deriv_width  <= '0;
              out_data_r.result_term  <= 4'd0;
              out_data_r.last         <= 1'b1;
              out_valid_r             <= 1'b1;
              state_r                 <= S_OUT;
            end
            OS_ROWP, OS_ROWC: begin
              if (ostep_r == OS_ROWP) begin
                p_r     <= mq_res;
                ostep_r <= OS_ROWC;
              end else begin
                dc_r    <= sat32(mq_res);
                ostep_r <= OS_ROWW;
              end
              mq_ma_r  <= mag47(ln_a);
              mq_mb_r  <= ln_b;
              mq_neg_r <= ln_a[47] ^ ln_bneg;
              acc_r    <= '0;
              mq_cnt_r <= '0;
              state_r  <= S_MQ;
            end
            default: begin
              out_data_r.value        <= sat32(p_r);
              out_data_r.deriv_center <= dc_r;
              out_data_r.deriv_width  <= sat32(mq_res);
              out_data_r.result_term  <= 4'(k_inc);
              out_data_r.last         <= (k_inc == nterms_r);
              out_valid_r             <= 1'b1;
              k_r                     <= k_inc;
              state_r                 <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_data_r.last) begin
              state_r <= S_IDLE;
            end else begin
              mq_ma_r  <= mag47(ln_a);
              mq_mb_r  <= ln_b;
              mq_neg_r <= ln_a[47] ^ ln_bneg;
              acc_r    <= '0;
              mq_cnt_r <= '0;
              ostep_r  <= OS_ROWP;
              state_r  <= S_MQ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (k_r <= nterms_r))
    else $error("term counter past term count");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> in_ready)
    else $error("no return to idle after last transfer");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWT))
    else $error("divider finished outside its wait state");

endmodule
